### hw/rtl/element_dof_index_generator_top_defines.svh
// assertion helpers for the element dof index generator
`ifndef ELEMENT_DOF_INDEX_GENERATOR_TOP_DEFINES_SVH
`define ELEMENT_DOF_INDEX_GENERATOR_TOP_DEFINES_SVH

// condition must hold whenever the antecedent holds, same cycle
`define EDIG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the antecedent
`define EDIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/edig_pkg.sv
package edig_pkg;

    // field and internal widths
    localparam int ORD_W      = 3;
    localparam int DOFS_W     = 6;
    localparam int ELEM_W     = 6;
    localparam int ADDR_IN_W  = 12;
    localparam int OUT_W      = 24;
    localparam int IDX_W      = 16;
    localparam int PROD_W     = 9;
    localparam int EXT_W      = 4;
    localparam int STRIDE_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_ORDER    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOFS_PER_SIDE = 1'd1;
    localparam logic [ORD_W-1:0]     ORDER_RESET       = 3'd3;
    localparam logic [DOFS_W-1:0]    DOFS_RESET        = 6'd12;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_ELEM  = 1'b1;

    typedef enum logic [1:0] {
        KIND_NODE  = 2'd0,
        KIND_XEDGE = 2'd1,
        KIND_YEDGE = 2'd2,
        KIND_FACE  = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic base;
        logic issue;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last_dof;
        logic can_issue;
    } t_status;

endpackage

### hw/rtl/edig_ram.sv
module edig_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/edig_ctrl.sv
module edig_ctrl import edig_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_req_type,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_BASE = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // commands
    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_valid;
        o_cmd.prep   = (r_state == S_PREP);
        o_cmd.base   = (r_state == S_BASE);
        o_cmd.issue  = (r_state == S_RUN) && i_status.can_issue;
    end

    assign o_stall = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_req_type == REQ_ELEM)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_BASE;
            S_BASE: begin
                n_state = i_status.empty ? S_IDLE : S_RUN;
            end
            S_RUN: begin
                if (o_cmd.issue && i_status.last_dof) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/edig_dpath.sv
module edig_dpath import edig_pkg::*; #(
    parameter int MAP_DEPTH         = 4096,
    parameter int GLOBAL_INDEX_BITS = 24,
    parameter int MAX_ORDER         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_type,
    input  logic [1:0]            i_entity_kind,
    input  logic                  i_global_mode,
    input  logic [ELEM_W-1:0]     i_elem_x,
    input  logic [ELEM_W-1:0]     i_elem_y,
    input  logic [ADDR_IN_W-1:0]  i_table_addr,
    input  logic [OUT_W-1:0]      i_table_value,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_dof_index,
    output logic                  o_last,
    output logic                  o_range_error
);

    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int MEM_DEPTH = 4 * (2 ** AW);
    localparam int MEM_AW    = AW + 2;

    // configuration registers
    logic [ORD_W-1:0]  r_elem_order;
    logic [DOFS_W-1:0] r_dofs_per_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_order    <= ORDER_RESET;
            r_dofs_per_side <= DOFS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ELEM_ORDER:    r_elem_order    <= i_cfg_data[ORD_W-1:0];
                REG_DOFS_PER_SIDE: r_dofs_per_side <= i_cfg_data[DOFS_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture, order saturated
    t_kind             r_kind;
    logic              r_global;
    logic [ELEM_W-1:0] r_ex;
    logic [ELEM_W-1:0] r_ey;
    logic [ORD_W-1:0]  r_ord;
    logic [ORD_W-1:0]  n_ord;

    assign n_ord = (32'(r_elem_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : r_elem_order;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_req_type == REQ_ELEM)) begin
            r_kind   <= t_kind'(i_entity_kind);
            r_global <= i_global_mode;
            r_ex     <= i_elem_x;
            r_ey     <= i_elem_y;
            r_ord    <= n_ord;
        end
    end

    // extents, stride and element offsets
    logic [PROD_W-1:0]   r_ey_ord;
    logic [PROD_W-1:0]   r_ex_ord;
    logic [EXT_W-1:0]    r_rows;
    logic [EXT_W-1:0]    r_cols;
    logic [STRIDE_W-1:0] r_stride;
    logic [EXT_W-1:0]    n_rows;
    logic [EXT_W-1:0]    n_cols;
    logic [STRIDE_W-1:0] n_stride;

    always_comb begin
        unique case (r_kind)
            KIND_NODE: begin
                n_rows   = EXT_W'(r_ord) + 1'b1;
                n_cols   = EXT_W'(r_ord) + 1'b1;
                n_stride = STRIDE_W'(r_dofs_per_side) + 1'b1;
            end
            KIND_XEDGE: begin
                n_rows   = EXT_W'(r_ord);
                n_cols   = EXT_W'(r_ord) + 1'b1;
                n_stride = STRIDE_W'(r_dofs_per_side) + 1'b1;
            end
            KIND_YEDGE: begin
                n_rows   = EXT_W'(r_ord) + 1'b1;
                n_cols   = EXT_W'(r_ord);
                n_stride = STRIDE_W'(r_dofs_per_side);
            end
            default: begin
                n_rows   = EXT_W'(r_ord);
                n_cols   = EXT_W'(r_ord);
                n_stride = STRIDE_W'(r_dofs_per_side);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_ey_ord <= PROD_W'(r_ey) * PROD_W'(r_ord);
            r_ex_ord <= PROD_W'(r_ex) * PROD_W'(r_ord);
            r_rows   <= n_rows;
            r_cols   <= n_cols;
            r_stride <= n_stride;
        end
    end

    // index walk: row base plus column, one index per issue
    logic [IDX_W-1:0] r_row_base;
    logic [IDX_W-1:0] r_idx;
    logic [ORD_W-1:0] r_r;
    logic [ORD_W-1:0] r_c;
    logic [IDX_W-1:0] n_base;
    logic [IDX_W-1:0] n_next_row;
    logic             last_col;
    logic             last_row;

    assign n_base     = IDX_W'(r_ey_ord) * IDX_W'(r_stride) + IDX_W'(r_ex_ord);
    assign n_next_row = r_row_base + IDX_W'(r_stride);
    assign last_col   = ({1'b0, r_c} == (r_cols - 1'b1));
    assign last_row   = ({1'b0, r_r} == (r_rows - 1'b1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_row_base <= n_base;
            r_idx      <= n_base;
            r_r        <= '0;
            r_c        <= '0;
        end else if (i_cmd.issue) begin
            if (last_col) begin
                r_c        <= '0;
                r_r        <= r_r + 1'b1;
                r_row_base <= n_next_row;
                r_idx      <= n_next_row;
            end else begin
                r_c   <= r_c + 1'b1;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // map tables, one region per entity kind
    logic                         range_err;
    logic                         mem_we;
    logic [MEM_AW-1:0]            mem_waddr;
    logic [MEM_AW-1:0]            mem_raddr;
    logic [GLOBAL_INDEX_BITS-1:0] mem_wdata;
    logic [GLOBAL_INDEX_BITS-1:0] mem_rdata;

    assign range_err = !(32'(r_idx) < MAP_DEPTH);
    assign mem_we    = i_cmd.accept && (i_req_type == REQ_WRITE)
                       && (32'(i_table_addr) < MAP_DEPTH);
    assign mem_waddr = {i_entity_kind, AW'(i_table_addr)};
    assign mem_wdata = GLOBAL_INDEX_BITS'(i_table_value);
    assign mem_raddr = {r_kind, r_idx[AW-1:0]};

    edig_ram #(
        .WIDTH (GLOBAL_INDEX_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.issue && !range_err),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // read stage and output register
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_err;
    logic             r_s1_last;
    logic             r_s1_global;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_index;
    logic             r_out_last;
    logic             r_out_err;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_idx    <= r_idx;
            r_s1_err    <= range_err;
            r_s1_last   <= last_col && last_row;
            r_s1_global <= r_global;
        end
        if (out_free && r_s1_valid) begin
            if (r_s1_err) begin
                r_out_index <= '0;
            end else if (r_s1_global) begin
                r_out_index <= OUT_W'(mem_rdata);
            end else begin
                r_out_index <= OUT_W'(r_s1_idx);
            end
            r_out_last <= r_s1_last;
            r_out_err  <= r_s1_err;
        end
    end

    // status to controller
    always_comb begin
        o_status.empty     = (r_rows == '0) || (r_cols == '0);
        o_status.last_dof  = last_col && last_row;
        o_status.can_issue = !r_s1_valid || out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_dof_index   = r_out_index;
    assign o_last        = r_out_last;
    assign o_range_error = r_out_err;

endmodule

### hw/rtl/element_dof_index_generator_top.sv
// Element dof index generator.
// Input channel (i_valid / o_stall): a transfer with i_req_type = 0 writes one
// map entry (i_entity_kind, i_table_addr, i_table_value) and gives
// no result; with i_req_type = 1 it requests all dof indices of the element at
// (i_elem_x, i_elem_y) for i_entity_kind, local or mapped by i_global_mode.
// Output channel (o_valid / i_stall): one transfer per dof, row by row,
// o_last on the final one, o_range_error with index 0 when the local index
// falls outside the map.
// Configuration: i_cfg_we writes elem_order (index 0) or dofs_per_side
// (index 1); the user must write only while the block is idle (not enforced).
// A request first registers the element offsets, then the row base, and then
// issues rows*cols indices, one per cycle while the receiver does not stall,
// from the index counter and the single map read port: up to 64 indices at
// order 7, 16 at order 3. Each passes the read stage and output register.
// o_stall is high after the request transfer until the last index is issued.
// A stalled receiver holds the output register and read stage; issue pauses.
// Reset restores elem_order 3 and dofs_per_side 12 and empties the pipeline;
// map contents are undefined until written.
`include "element_dof_index_generator_top_defines.svh"

module element_dof_index_generator_top import edig_pkg::*; #(
    parameter int MAP_DEPTH         = 4096,
    parameter int GLOBAL_INDEX_BITS = 24,
    parameter int MAX_ORDER         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [1:0]            i_entity_kind,
    input  logic                  i_global_mode,
    input  logic [ELEM_W-1:0]     i_elem_x,
    input  logic [ELEM_W-1:0]     i_elem_y,
    input  logic [ADDR_IN_W-1:0]  i_table_addr,
    input  logic [OUT_W-1:0]      i_table_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_dof_index,
    output logic                  o_last,
    output logic                  o_range_error
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    edig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // index arithmetic, map tables and output pipeline
    edig_dpath #(
        .MAP_DEPTH         (MAP_DEPTH),
        .GLOBAL_INDEX_BITS (GLOBAL_INDEX_BITS),
        .MAX_ORDER         (MAX_ORDER)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_entity_kind (i_entity_kind),
        .i_global_mode (i_global_mode),
        .i_elem_x      (i_elem_x),
        .i_elem_y      (i_elem_y),
        .i_table_addr  (i_table_addr),
        .i_table_value (i_table_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dof_index   (o_dof_index),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

    // checks
    `EDIG_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_valid && o_range_error, o_dof_index == '0, "range error with nonzero index")
    `EDIG_ASSERT_SAME(a_issue_room, i_clk, i_rst_n, cmd.issue, status.can_issue && o_stall, "issue without room or while accepting input")
    `EDIG_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_req_type == REQ_ELEM), o_stall, "request transfer not followed by busy")

endmodule
